/* rtl/fct_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fct_pkg: shared types and constants of the frustum culling plane test
// Operation and class codes, arithmetic widths, the per-plane flag word and
// the helper that takes a signed 16-bit lane out of a packed vector.
// ---------------------------------------------------------------------------
package fct_pkg;

    localparam int ACC_W   = 38;
    localparam int FRAC_UP = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_PLANES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MARGIN = 3'd6;
    localparam logic [14:0]          MARGIN_RESET   = 15'd512;

    localparam logic [1:0] OP_POINT    = 2'd0;
    localparam logic [1:0] OP_SPHERE   = 2'd1;
    localparam logic [1:0] OP_BOX      = 2'd2;
    localparam logic [1:0] OP_CLASSIFY = 2'd3;

    localparam logic [1:0] POS_INSIDE = 2'd0;
    localparam logic [1:0] POS_SPAN   = 2'd1;
    localparam logic [1:0] POS_BACK   = 2'd2;

    typedef struct packed {
        logic rej;
        logic span;
        logic back;
    } t_flags;

    function automatic logic signed [15:0] lane16(input logic [63:0] word,
                                                  input logic [1:0]  idx);
        logic [63:0] shifted;
        shifted = word >> {idx, 4'd0};
        return $signed(shifted[15:0]);
    endfunction

endpackage
`default_nettype wire

/* rtl/fct_plane.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fct_plane: test of one object against one plane
// Forms the signed distance of the centre and the projected box extent in
// Q.14, then the reject, spanning and back flags for the selected operation.
// ---------------------------------------------------------------------------
module fct_plane
    import fct_pkg::*;
(
    input  wire logic [63:0] i_plane,
    input  wire logic [1:0]  i_op,
    input  wire logic [47:0] i_center,
    input  wire logic [14:0] i_radius,
    input  wire logic [47:0] i_half_axis_one,
    input  wire logic [47:0] i_half_axis_two,
    input  wire logic [47:0] i_half_axis_three,
    input  wire logic [14:0] i_margin,
    output t_flags           o_flags
);

    logic signed [ACC_W-1:0] dist_q;
    logic signed [ACC_W-1:0] dot_h1;
    logic signed [ACC_W-1:0] dot_h2;
    logic signed [ACC_W-1:0] dot_h3;
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] rad_q;
    logic signed [ACC_W-1:0] mar_q;

    function automatic logic signed [ACC_W-1:0] dot3(input logic [63:0] pl,
                                                     input logic [47:0] vec);
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        px = lane16(pl, 2'd0) * lane16({16'd0, vec}, 2'd0);
        py = lane16(pl, 2'd1) * lane16({16'd0, vec}, 2'd1);
        pz = lane16(pl, 2'd2) * lane16({16'd0, vec}, 2'd2);
        return ACC_W'(px) + ACC_W'(py) + ACC_W'(pz);
    endfunction

    function automatic logic signed [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    always_comb begin
        dist_q = dot3(i_plane, i_center) + (ACC_W'(lane16(i_plane, 2'd3)) <<< FRAC_UP);
        dot_h1 = dot3(i_plane, i_half_axis_one);
        dot_h2 = dot3(i_plane, i_half_axis_two);
        dot_h3 = dot3(i_plane, i_half_axis_three);
        ext    = mag(dot_h1) + mag(dot_h2) + mag(dot_h3);
        rad_q  = $signed({{(ACC_W-15){1'b0}}, i_radius}) <<< FRAC_UP;
        mar_q  = $signed({{(ACC_W-15){1'b0}}, i_margin}) <<< FRAC_UP;

        o_flags.span = (dist_q <= ext);
        o_flags.back = ((dist_q + mar_q + ext) < 0);
        case (i_op)
            OP_POINT:    o_flags.rej = (dist_q < 0);
            OP_SPHERE:   o_flags.rej = ((dist_q + rad_q) <= 0);
            OP_BOX:      o_flags.rej = ((dist_q + ext) <= 0);
            OP_CLASSIFY: o_flags.rej = o_flags.back;
            default:     o_flags.rej = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/fct_reduce.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// fct_reduce: merge of the per-plane flags into one result word
// Any rejecting plane clears visible; for classification a back plane wins
// over a spanning one.
// ---------------------------------------------------------------------------
module fct_reduce
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6
) (
    input  wire t_flags [NUM_PLANES-1:0] i_flags,
    input  wire logic [1:0]              i_op,
    output logic                         o_visible,
    output logic [1:0]                   o_position
);

    logic any_rej;
    logic any_span;
    logic any_back;

    always_comb begin
        any_rej  = 1'b0;
        any_span = 1'b0;
        any_back = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            any_rej  = any_rej  | i_flags[p].rej;
            any_span = any_span | i_flags[p].span;
            any_back = any_back | i_flags[p].back;
        end
        o_visible = ~any_rej;
        if (i_op != OP_CLASSIFY) begin
            o_position = POS_INSIDE;
        end else if (any_back) begin
            o_position = POS_BACK;
        end else if (any_span) begin
            o_position = POS_SPAN;
        end else begin
            o_position = POS_INSIDE;
        end
    end

endmodule
`default_nettype wire

/* rtl/frustum_cull_test.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// frustum_cull_test: view frustum culling against configured planes
// Tests a point, sphere or oriented box against the frustum planes.
//
// A word is accepted at a rising edge with start high and busy low. Busy is
// high only while reset is applied and in the cycle after it; otherwise a new
// word may be started in every cycle. The result appears on o_visible and
// o_position with o_valid high for exactly one cycle, after the word has passed
// the input register, the per-plane flag register and the result register.
// The receiver cannot stall the block, so results stream out at the input rate.
// The user must write planes and the back margin through the plain write port
// only while no test is in flight; the block itself does not enforce it.
// Reset clears the planes to zero, sets the margin to 512 and drops all words
// in flight.
// ---------------------------------------------------------------------------
module frustum_cull_test
    import fct_pkg::*;
#(
    parameter int NUM_PLANES = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_op,
    input  wire logic [47:0]           i_center,
    input  wire logic [14:0]           i_radius,
    input  wire logic [47:0]           i_half_axis_one,
    input  wire logic [47:0]           i_half_axis_two,
    input  wire logic [47:0]           i_half_axis_three,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic                       o_visible,
    output logic [1:0]                 o_position
);

    logic [63:0] r_plane [CFG_PLANES];
    logic [14:0] r_margin;
    logic        r_live;

    logic        r_in_vld;
    logic [1:0]  r_op;
    logic [47:0] r_center;
    logic [14:0] r_radius;
    logic [47:0] r_h1;
    logic [47:0] r_h2;
    logic [47:0] r_h3;

    t_flags [NUM_PLANES-1:0] n_flags;
    t_flags [NUM_PLANES-1:0] r_flags;
    logic                    r_flg_vld;
    logic [1:0]              r_flg_op;

    logic       n_visible;
    logic [1:0] n_position;
    logic       r_out_vld;
    logic       r_visible;
    logic [1:0] r_position;

    logic accept;

    assign busy   = ~r_live;
    assign accept = start & r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= 1'b0;
            r_margin <= MARGIN_RESET;
            for (int i = 0; i < CFG_PLANES; i++) begin
                r_plane[i] <= '0;
            end
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_MARGIN) begin
                    r_margin <= i_cfg_data[14:0];
                end
                for (int i = 0; i < CFG_PLANES; i++) begin
                    if (i_cfg_idx == CFG_IDX_W'(i)) begin
                        r_plane[i] <= i_cfg_data;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_center <= i_center;
            r_radius <= i_radius;
            r_h1     <= i_half_axis_one;
            r_h2     <= i_half_axis_two;
            r_h3     <= i_half_axis_three;
        end
        r_flags    <= n_flags;
        r_flg_op   <= r_op;
        r_visible  <= n_visible;
        r_position <= n_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_flg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_flg_vld <= r_in_vld;
            r_out_vld <= r_flg_vld;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        logic [63:0] plane_word;
        if (p < CFG_PLANES) begin : g_cfg
            assign plane_word = r_plane[p];
        end else begin : g_zero
            assign plane_word = '0;
        end
        fct_plane u_plane (
            .i_plane           (plane_word),
            .i_op              (r_op),
            .i_center          (r_center),
            .i_radius          (r_radius),
            .i_half_axis_one   (r_h1),
            .i_half_axis_two   (r_h2),
            .i_half_axis_three (r_h3),
            .i_margin          (r_margin),
            .o_flags           (n_flags[p])
        );
    end

    fct_reduce #(
        .NUM_PLANES (NUM_PLANES)
    ) u_reduce (
        .i_flags    (r_flags),
        .i_op       (r_flg_op),
        .o_visible  (n_visible),
        .o_position (n_position)
    );

    assign o_valid    = r_out_vld;
    assign o_visible  = r_visible;
    assign o_position = r_position;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted word did not produce a result after three cycles");

    a_back_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_position == POS_BACK) |-> !o_visible)
        else $error("object classed as back but reported visible");

    a_class_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_position != POS_INSIDE) |-> ($past(r_flg_op) == OP_CLASSIFY))
        else $error("non-inside class reported for a test that does not classify");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe straight after reset");

endmodule
`default_nettype wire

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the frustum culling plane test
// Points, spheres and oriented boxes are sent against several plane sets and
// back margins. The verdict of every word is worked out here from local
// copies of the registers and compared with what the block reports.
// ---------------------------------------------------------------------------
module tb;
    import fct_pkg::*;

    localparam int NUM_PLANES = 6;
    localparam int IDLE_LIMIT = 500;
    localparam int Q14        = 16384;
    localparam int STREAM_LEN = 140;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic       visible;
        logic [1:0] position;
    } t_verdict;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  start             = 1'b0;
    logic                  busy;
    logic [1:0]            i_op              = OP_POINT;
    logic [47:0]           i_center          = '0;
    logic [14:0]           i_radius          = '0;
    logic [47:0]           i_half_axis_one   = '0;
    logic [47:0]           i_half_axis_two   = '0;
    logic [47:0]           i_half_axis_three = '0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  o_valid;
    logic                  o_visible;
    logic [1:0]            o_position;

    logic [63:0] plane_copy [NUM_PLANES] = '{default: '0};
    logic [63:0] plane_plan [NUM_PLANES] = '{default: '0};
    logic [14:0] margin_copy = MARGIN_RESET;
    t_verdict    pending_verdicts [$];
    int          errors        = 0;
    int          idle_cycles   = 0;
    int          gap_pct       = 0;
    int          frustum_half  = 1024;

    frustum_cull_test #(
        .NUM_PLANES(NUM_PLANES)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_center          (i_center),
        .i_radius          (i_radius),
        .i_half_axis_one   (i_half_axis_one),
        .i_half_axis_two   (i_half_axis_two),
        .i_half_axis_three (i_half_axis_three),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_visible         (o_visible),
        .o_position        (o_position)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint lane(input logic [63:0] packed_word, input int k);
        logic signed [15:0] v;
        v = packed_word[16*k +: 16];
        return longint'(v);
    endfunction

    function automatic longint normal_dot(input logic [63:0] plane, input logic [47:0] vec);
        return lane(plane, 0) * lane({16'h0, vec}, 0)
             + lane(plane, 1) * lane({16'h0, vec}, 1)
             + lane(plane, 2) * lane({16'h0, vec}, 2);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_verdict judge_object(input logic [1:0] op, input logic [47:0] ctr,
                                              input logic [14:0] rad,
                                              input logic [47:0] h1, h2, h3);
        t_verdict v;
        longint   dist_q;
        longint   ext;
        longint   rad_q;
        longint   marg_q;
        bit       decided;
        v.visible  = 1'b1;
        v.position = POS_INSIDE;
        decided    = 1'b0;
        rad_q      = longint'(rad) * Q14;
        marg_q     = longint'(margin_copy) * Q14;
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (!decided) begin
                dist_q = normal_dot(plane_copy[p], ctr) + lane(plane_copy[p], 3) * Q14;
                ext    = magnitude(normal_dot(plane_copy[p], h1))
                       + magnitude(normal_dot(plane_copy[p], h2))
                       + magnitude(normal_dot(plane_copy[p], h3));
                case (op)
                    OP_POINT: begin
                        if (dist_q < 0) begin
                            v.visible = 1'b0;
                            decided   = 1'b1;
                        end
                    end
                    OP_SPHERE: begin
                        if (dist_q <= -rad_q) begin
                            v.visible = 1'b0;
                            decided   = 1'b1;
                        end
                    end
                    OP_BOX: begin
                        if (dist_q <= -ext) begin
                            v.visible = 1'b0;
                            decided   = 1'b1;
                        end
                    end
                    OP_CLASSIFY: begin
                        if (dist_q <= ext)
                            v.position = POS_SPAN;
                        if (dist_q + marg_q < -ext) begin
                            v.position = POS_BACK;
                            v.visible  = 1'b0;
                            decided    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        return v;
    endfunction

    function automatic logic [63:0] pack_plane(input int a, b, c, d);
        return {d[15:0], c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic logic [47:0] pack3(input int x, y, z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic int spread(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int snap(input int half);
        return ($urandom_range(0, 1) ? half : -half) + spread(4);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("tb: mismatch in %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (o_valid === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected word", 0, int'({o_visible, o_position}));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_visible !== want.visible)
                    report_mismatch("visible", int'(want.visible), int'(o_visible));
                if (o_position !== want.position)
                    report_mismatch("position", int'(want.position), int'(o_position));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_object(input logic [1:0] op, input logic [47:0] ctr,
                               input logic [14:0] rad, input logic [47:0] h1, h2, h3);
        int pause;
        start             <= 1'b1;
        i_op              <= op;
        i_center          <= ctr;
        i_radius          <= rad;
        i_half_axis_one   <= h1;
        i_half_axis_two   <= h2;
        i_half_axis_three <= h3;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        pending_verdicts.push_back(judge_object(op, ctr, rad, h1, h2, h3));
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            pause = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    task automatic send_random;
        logic [1:0]  op;
        logic [47:0] ctr;
        logic [47:0] h [3];
        logic [14:0] rad;
        int          roll;
        op   = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            ctr = 48'({$urandom, $urandom});
            rad = 15'($urandom);
            for (int j = 0; j < 3; j++)
                h[j] = 48'({$urandom, $urandom});
        end else begin
            for (int k = 0; k < 3; k++)
                ctr[16*k +: 16] = 16'((roll < 45) ? snap(frustum_half) : spread(12000));
            rad = 15'($urandom_range(0, (roll < 45) ? 3 : 4000));
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    h[j][16*k +: 16] = 16'(spread((roll < 45) ? 2 : 2500));
        end
        send_object(op, ctr, rad, h[0], h[1], h[2]);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < CFG_PLANES)
            plane_copy[idx] = data;
        else if (idx == CFG_IDX_MARGIN)
            margin_copy = data[14:0];
    endtask

    task automatic cfg_close;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [63:0] margin_data);
        logic [CFG_IDX_W-1:0] idx;
        for (int p = 0; p < NUM_PLANES; p++) begin
            idx = p[CFG_IDX_W-1:0];
            cfg_write(idx, plane_plan[p]);
        end
        cfg_write(CFG_IDX_MARGIN, margin_data);
        cfg_close();
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic plan_aligned(input int half);
        frustum_half  = half;
        plane_plan[0] = pack_plane(Q14, 0, 0, half);
        plane_plan[1] = pack_plane(-Q14, 0, 0, half);
        plane_plan[2] = pack_plane(0, Q14, 0, half);
        plane_plan[3] = pack_plane(0, -Q14, 0, half);
        plane_plan[4] = pack_plane(0, 0, Q14, half);
        plane_plan[5] = pack_plane(0, 0, -Q14, half);
    endtask

    task automatic plan_tilted;
        int n [3];
        frustum_half = 4096;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < 3; k++)
                n[k] = spread(2000);
            n[p / 2] = ((p % 2) ? -1 : 1) * (Q14 - int'($urandom_range(0, 3000)));
            plane_plan[p] = pack_plane(n[0], n[1], n[2], $urandom_range(256, 8192));
        end
    endtask

    function automatic logic [63:0] margin_word(input logic [14:0] margin);
        logic [63:0] w;
        w = {$urandom, $urandom};
        w[14:0] = margin;
        return w;
    endfunction

    task automatic test_cleared_planes;
        send_object(OP_POINT, '0, '0, '0, '0, '0);
        send_object(OP_SPHERE, '0, '0, '0, '0, '0);
        send_object(OP_SPHERE, '0, 15'h7FFF, '0, '0, '0);
        send_object(OP_BOX, '0, '0, '0, '0, '0);
        send_object(OP_CLASSIFY, pack3(100, -100, 7), '0, pack3(1, 2, 3), pack3(-4, 5, 6),
                    pack3(7, -8, 9));
        drain();
    endtask

    task automatic test_boundaries;
        plan_aligned(1024);
        apply_setting({49'h0, MARGIN_RESET});
        send_object(OP_POINT, pack3(-1024, 0, 0), '0, '0, '0, '0);
        send_object(OP_POINT, pack3(-1025, 0, 0), '0, '0, '0, '0);
        send_object(OP_POINT, pack3(0, 0, 1024), '0, '0, '0, '0);
        send_object(OP_POINT, pack3(0, 0, 1025), '0, '0, '0, '0);
        send_object(OP_SPHERE, pack3(-1280, 0, 0), 15'd256, '0, '0, '0);
        send_object(OP_SPHERE, pack3(-1279, 0, 0), 15'd256, '0, '0, '0);
        send_object(OP_BOX, pack3(0, 1280, 0), '0, pack3(0, 100, 0), pack3(0, -56, 0),
                    pack3(0, 100, 0));
        send_object(OP_BOX, pack3(0, 1279, 0), '0, pack3(0, 100, 0), pack3(0, -56, 0),
                    pack3(0, 100, 0));
        send_object(OP_CLASSIFY, '0, '0, pack3(10, 0, 0), pack3(0, 10, 0), pack3(0, 0, 10));
        send_object(OP_CLASSIFY, pack3(-768, 0, 0), '0, pack3(256, 0, 0), '0, '0);
        send_object(OP_CLASSIFY, pack3(-1793, 0, 0), '0, pack3(256, 0, 0), '0, '0);
        send_object(OP_CLASSIFY, pack3(-1792, 0, 0), '0, pack3(256, 0, 0), '0, '0);
        send_object(OP_POINT, {3{16'h8000}}, '0, '0, '0, '0);
        send_object(OP_SPHERE, {3{16'h7FFF}}, 15'h7FFF, '0, '0, '0);
        send_object(OP_BOX, {3{16'h8000}}, '0, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}});
        send_object(OP_CLASSIFY, {3{16'h7FFF}}, '0, {3{16'h8000}}, {3{16'h8000}},
                    {3{16'h8000}});
        drain();
    endtask

    task automatic test_margin_extremes;
        cfg_write(CFG_IDX_MARGIN, 64'h0);
        cfg_close();
        send_object(OP_CLASSIFY, pack3(-1281, 0, 0), '0, pack3(256, 0, 0), '0, '0);
        send_object(OP_CLASSIFY, pack3(-1280, 0, 0), '0, pack3(256, 0, 0), '0, '0);
        drain();
        cfg_write(CFG_IDX_MARGIN, margin_word(15'h7FFF));
        cfg_close();
        send_object(OP_CLASSIFY, {3{16'h8000}}, '0, '0, '0, '0);
        send_object(OP_CLASSIFY, {3{16'h8000}}, '0, {3{16'h8000}}, '0, '0);
        drain();
    endtask

    task automatic test_plane_extremes;
        for (int p = 0; p < NUM_PLANES; p++)
            plane_plan[p] = (p % 2) ? {4{16'h8000}} : {4{16'h7FFF}};
        apply_setting({49'h0, MARGIN_RESET});
        send_object(OP_POINT, {3{16'h7FFF}}, '0, '0, '0, '0);
        send_object(OP_SPHERE, {3{16'h8000}}, 15'h7FFF, '0, '0, '0);
        send_object(OP_BOX, {3{16'h8000}}, '0, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}});
        send_object(OP_CLASSIFY, {3{16'h7FFF}}, '0, {3{16'h7FFF}}, {3{16'h7FFF}},
                    {3{16'h7FFF}});
        drain();
    endtask

    task automatic test_spare_index;
        plan_aligned(2048);
        apply_setting(margin_word(MARGIN_RESET));
        cfg_write(CFG_IDX_SPARE, '1);
        cfg_close();
        repeat (6) send_random();
        drain();
    endtask

    task automatic test_random_stream;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    plan_aligned(2048);
                    apply_setting(margin_word(MARGIN_RESET));
                    gap_pct = 40;
                end
                1: begin
                    plan_tilted();
                    apply_setting(margin_word(15'h0));
                    gap_pct = 20;
                end
                2: begin
                    plan_tilted();
                    apply_setting(margin_word(15'h7FFF));
                    gap_pct = 60;
                end
                3: begin
                    for (int p = 0; p < NUM_PLANES; p++)
                        plane_plan[p] = {$urandom, $urandom};
                    apply_setting(margin_word(15'($urandom)));
                    gap_pct = 30;
                end
                4: begin
                    for (int p = 0; p < NUM_PLANES; p++)
                        plane_plan[p] = '1;
                    apply_setting(margin_word(15'($urandom)));
                    gap_pct = 30;
                end
                5: begin
                    plan_aligned($urandom_range(16, 12000));
                    apply_setting(margin_word(15'($urandom_range(0, 2048))));
                    gap_pct = 0;
                end
                6: begin
                    plan_tilted();
                    apply_setting(margin_word(15'($urandom)));
                    gap_pct = 40;
                end
                default: begin
                    plan_aligned(4096);
                    apply_setting(margin_word(15'($urandom_range(0, 2048))));
                    gap_pct = 0;
                end
            endcase
            repeat (STREAM_LEN) send_random();
            drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_planes();
        test_boundaries();
        test_margin_extremes();
        test_plane_extremes();
        test_spare_index();
        test_random_stream();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/fct_pkg.sv
rtl/fct_plane.sv
rtl/fct_reduce.sv
rtl/frustum_cull_test.sv
dv/tb.sv
